FILE: rtl/core/npc_pkg.sv
`default_nettype none

package npc_pkg;

   // field widths
   localparam int TIME_W      = 48;
   localparam int ANGLE_W     = 15;
   localparam int OUT_ANGLE_W = ANGLE_W + 1;
   localparam int FIT_W       = 16;
   localparam int CONFIRM_W   = 32;
   localparam int LIMIT_W     = 15;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // sample bound and the widths that follow from it
   localparam int MAX_SAMPLES = 65535;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int TOTAL_W     = ANGLE_W + COUNT_W;

   // a mean of angles always fits an angle, so the quotient has angle width
   localparam int QUOT_W = ANGLE_W;
   localparam int STEP_W = $clog2(QUOT_W);

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONFIRM_TIME = 2'd0,
      CSR_YAW_LIMIT    = 2'd1,
      CSR_PITCH_LIMIT  = 2'd2
   } csr_index_type;

   // register reset values
   localparam logic [CONFIRM_W-1:0] CONFIRM_TIME_RESET = CONFIRM_W'(1000000);
   localparam logic [LIMIT_W-1:0]   YAW_LIMIT_RESET    = LIMIT_W'(640);
   localparam logic [LIMIT_W-1:0]   PITCH_LIMIT_RESET  = LIMIT_W'(640);

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear;
      logic mark_time;
      logic track;
      logic restart_window;
      logic accumulate;
      logic div_start;
      logic set_offsets;
      logic load_out;
   } npc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic restart;
      logic skip;
      logic calibrated;
      logic spread_over;
      logic confirm_wait;
      logic div_busy;
      logic out_free;
   } npc_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/npc_divider.sv
`default_nettype none

module npc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [npc_pkg::TOTAL_W-1:0]    dividend,
   input  logic [npc_pkg::COUNT_W-1:0]    divisor,
   output logic                           busy,
   output logic [npc_pkg::QUOT_W-1:0]     quotient
);
   import npc_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0]  divisor_ff, divisor_in;
   logic [COUNT_W:0]    trial;
   logic                fits;

   // restoring division, one quotient bit a cycle; the upper dividend bits
   // start as remainder since the quotient never exceeds the angle width
   assign trial = {rem_ff, shift_ff[QUOT_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(QUOT_W - 1);
         rem_in     = dividend[TOTAL_W-1:QUOT_W];
         shift_in   = dividend[QUOT_W-1:0];
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? COUNT_W'(trial - {1'b0, divisor_ff}) : trial[COUNT_W-1:0];
         shift_in = {shift_ff[QUOT_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

`default_nettype wire

FILE: rtl/core/npc_datapath.sv
`default_nettype none

module npc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  npc_pkg::npc_cmd_type                cmd,
   output npc_pkg::npc_status_type             status,
   input  logic                                csr_write_enable,
   input  logic [npc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                req_func,
   input  logic [npc_pkg::TIME_W-1:0]          req_sample_time,
   input  logic                                req_angles_ok,
   input  logic signed [npc_pkg::ANGLE_W-1:0]  req_yaw_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]  req_pitch_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]  req_roll_in,
   input  logic [npc_pkg::FIT_W-1:0]           req_fit_error_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_yaw_out,
   output logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_pitch_out,
   output logic signed [npc_pkg::ANGLE_W-1:0]  rsp_roll_out,
   output logic [npc_pkg::FIT_W-1:0]           rsp_fit_error_out
);
   import npc_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SAMPLES);

   // configuration
   logic [CONFIRM_W-1:0] confirm_time_ff, confirm_time_in;
   logic [LIMIT_W-1:0]   yaw_limit_ff, yaw_limit_in;
   logic [LIMIT_W-1:0]   pitch_limit_ff, pitch_limit_in;

   // captured sample
   logic                      s_func_ff, s_func_in;
   logic [TIME_W-1:0]         s_time_ff, s_time_in;
   logic                      s_ok_ff, s_ok_in;
   logic signed [ANGLE_W-1:0] s_yaw_ff, s_yaw_in;
   logic signed [ANGLE_W-1:0] s_pitch_ff, s_pitch_in;
   logic signed [ANGLE_W-1:0] s_roll_ff, s_roll_in;
   logic [FIT_W-1:0]          s_fit_ff, s_fit_in;

   // calibration state
   logic                      calibrated_ff, calibrated_in;
   logic                      seen_ff, seen_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic [TIME_W-1:0]         window_start_ff, window_start_in;
   logic signed [ANGLE_W-1:0] yaw_low_ff, yaw_low_in;
   logic signed [ANGLE_W-1:0] yaw_high_ff, yaw_high_in;
   logic signed [ANGLE_W-1:0] pitch_low_ff, pitch_low_in;
   logic signed [ANGLE_W-1:0] pitch_high_ff, pitch_high_in;
   logic signed [TOTAL_W-1:0] yaw_total_ff, yaw_total_in;
   logic signed [TOTAL_W-1:0] pitch_total_ff, pitch_total_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [QUOT_W-1:0]         yaw_offset_ff, yaw_offset_in;
   logic [QUOT_W-1:0]         pitch_offset_ff, pitch_offset_in;
   logic                      yaw_neg_ff, yaw_neg_in;
   logic                      pitch_neg_ff, pitch_neg_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [OUT_ANGLE_W-1:0]        rsp_yaw_ff, rsp_yaw_in;
   logic [OUT_ANGLE_W-1:0]        rsp_pitch_ff, rsp_pitch_in;
   logic [ANGLE_W-1:0]            rsp_roll_ff, rsp_roll_in;
   logic [FIT_W-1:0]              rsp_fit_ff, rsp_fit_in;

   // combinational helpers
   logic                      disabled;
   logic                      stale;
   logic [ANGLE_W:0]          yaw_spread;
   logic [ANGLE_W:0]          pitch_spread;
   logic [TIME_W-1:0]         elapsed;
   logic signed [TOTAL_W-1:0] yaw_ext;
   logic signed [TOTAL_W-1:0] pitch_ext;
   logic [TOTAL_W-1:0]        yaw_mag;
   logic [TOTAL_W-1:0]        pitch_mag;
   logic [TOTAL_W-1:0]        half_count;
   logic [TOTAL_W-1:0]        yaw_dividend;
   logic [TOTAL_W-1:0]        pitch_dividend;
   logic                      yaw_busy;
   logic                      pitch_busy;
   logic [QUOT_W-1:0]         yaw_quot;
   logic [QUOT_W-1:0]         pitch_quot;

   // sample classification
   assign disabled = (confirm_time_ff == '0) || (yaw_limit_ff == '0) || (pitch_limit_ff == '0);
   assign stale    = seen_ff && (s_time_ff <= last_time_ff);

   // spreads of the window, never negative
   assign yaw_spread   = {yaw_high_ff[ANGLE_W-1], yaw_high_ff}
                       - {yaw_low_ff[ANGLE_W-1], yaw_low_ff};
   assign pitch_spread = {pitch_high_ff[ANGLE_W-1], pitch_high_ff}
                       - {pitch_low_ff[ANGLE_W-1], pitch_low_ff};

   assign elapsed = s_time_ff - window_start_ff;

   assign yaw_ext   = {{(TOTAL_W-ANGLE_W){s_yaw_ff[ANGLE_W-1]}}, s_yaw_ff};
   assign pitch_ext = {{(TOTAL_W-ANGLE_W){s_pitch_ff[ANGLE_W-1]}}, s_pitch_ff};

   // rounded mean: magnitude plus half the count, sign put back afterwards
   assign yaw_mag    = yaw_total_ff[TOTAL_W-1] ? TOTAL_W'(-yaw_total_ff) : yaw_total_ff;
   assign pitch_mag  = pitch_total_ff[TOTAL_W-1] ? TOTAL_W'(-pitch_total_ff) : pitch_total_ff;
   assign half_count = TOTAL_W'(count_ff >> 1);
   assign yaw_dividend   = yaw_mag + half_count;
   assign pitch_dividend = pitch_mag + half_count;

   npc_divider yaw_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (yaw_dividend),
      .divisor  (count_ff),
      .busy     (yaw_busy),
      .quotient (yaw_quot)
   );

   npc_divider pitch_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (pitch_dividend),
      .divisor  (count_ff),
      .busy     (pitch_busy),
      .quotient (pitch_quot)
   );

   // status towards the controller
   always_comb begin
      status.restart      = s_func_ff;
      status.skip         = disabled || !s_ok_ff || stale;
      status.calibrated   = calibrated_ff;
      status.spread_over  = (yaw_spread > {1'b0, yaw_limit_ff})
                         || (pitch_spread > {1'b0, pitch_limit_ff});
      status.confirm_wait = (elapsed < TIME_W'(confirm_time_ff)) && (count_ff < MAX_COUNT);
      status.div_busy     = yaw_busy || pitch_busy;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // configuration writes
   always_comb begin
      confirm_time_in = confirm_time_ff;
      yaw_limit_in    = yaw_limit_ff;
      pitch_limit_in  = pitch_limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CONFIRM_TIME: confirm_time_in = csr_write_data[CONFIRM_W-1:0];
            CSR_YAW_LIMIT:    yaw_limit_in    = csr_write_data[LIMIT_W-1:0];
            CSR_PITCH_LIMIT:  pitch_limit_in  = csr_write_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample capture
   always_comb begin
      s_func_in  = s_func_ff;
      s_time_in  = s_time_ff;
      s_ok_in    = s_ok_ff;
      s_yaw_in   = s_yaw_ff;
      s_pitch_in = s_pitch_ff;
      s_roll_in  = s_roll_ff;
      s_fit_in   = s_fit_ff;
      if (cmd.capture) begin
         s_func_in  = req_func;
         s_time_in  = req_sample_time;
         s_ok_in    = req_angles_ok;
         s_yaw_in   = req_yaw_in;
         s_pitch_in = req_pitch_in;
         s_roll_in  = req_roll_in;
         s_fit_in   = req_fit_error_in;
      end
   end

   // calibration state updates
   always_comb begin
      calibrated_in   = calibrated_ff;
      seen_in         = seen_ff;
      last_time_in    = last_time_ff;
      window_start_in = window_start_ff;
      yaw_low_in      = yaw_low_ff;
      yaw_high_in     = yaw_high_ff;
      pitch_low_in    = pitch_low_ff;
      pitch_high_in   = pitch_high_ff;
      yaw_total_in    = yaw_total_ff;
      pitch_total_in  = pitch_total_ff;
      count_in        = count_ff;
      yaw_offset_in   = yaw_offset_ff;
      pitch_offset_in = pitch_offset_ff;
      yaw_neg_in      = yaw_neg_ff;
      pitch_neg_in    = pitch_neg_ff;

      if (cmd.clear) begin
         calibrated_in = 1'b0;
         seen_in       = 1'b0;
         count_in      = '0;
      end

      if (cmd.mark_time) begin
         seen_in      = 1'b1;
         last_time_in = s_time_ff;
      end

      // first sample opens the window, later ones widen the bounds
      if (cmd.track) begin
         if (count_ff == '0) begin
            window_start_in = s_time_ff;
            yaw_low_in      = s_yaw_ff;
            yaw_high_in     = s_yaw_ff;
            pitch_low_in    = s_pitch_ff;
            pitch_high_in   = s_pitch_ff;
         end else begin
            if (s_yaw_ff < yaw_low_ff)     yaw_low_in    = s_yaw_ff;
            if (s_yaw_ff > yaw_high_ff)    yaw_high_in   = s_yaw_ff;
            if (s_pitch_ff < pitch_low_ff) pitch_low_in  = s_pitch_ff;
            if (s_pitch_ff > pitch_high_ff) pitch_high_in = s_pitch_ff;
         end
      end

      // spread too wide: window restarts at this sample
      if (cmd.restart_window) begin
         window_start_in = s_time_ff;
         yaw_low_in      = s_yaw_ff;
         yaw_high_in     = s_yaw_ff;
         pitch_low_in    = s_pitch_ff;
         pitch_high_in   = s_pitch_ff;
         yaw_total_in    = yaw_ext;
         pitch_total_in  = pitch_ext;
         count_in        = COUNT_W'(1);
      end

      if (cmd.accumulate) begin
         yaw_total_in   = ((count_ff == '0) ? '0 : yaw_total_ff) + yaw_ext;
         pitch_total_in = ((count_ff == '0) ? '0 : pitch_total_ff) + pitch_ext;
         count_in       = count_ff + 1'b1;
      end

      if (cmd.div_start) begin
         yaw_neg_in   = yaw_total_ff[TOTAL_W-1];
         pitch_neg_in = pitch_total_ff[TOTAL_W-1];
      end

      if (cmd.set_offsets) begin
         yaw_offset_in   = yaw_neg_ff ? QUOT_W'(-yaw_quot) : yaw_quot;
         pitch_offset_in = pitch_neg_ff ? QUOT_W'(-pitch_quot) : pitch_quot;
         calibrated_in   = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_roll_in  = rsp_roll_ff;
      rsp_fit_in   = rsp_fit_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_yaw_in   = {s_yaw_ff[ANGLE_W-1], s_yaw_ff}
                      - {yaw_offset_ff[QUOT_W-1], yaw_offset_ff};
         rsp_pitch_in = {s_pitch_ff[ANGLE_W-1], s_pitch_ff}
                      - {pitch_offset_ff[QUOT_W-1], pitch_offset_ff};
         rsp_roll_in  = s_roll_ff;
         rsp_fit_in   = s_fit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_time_ff <= CONFIRM_TIME_RESET;
         yaw_limit_ff    <= YAW_LIMIT_RESET;
         pitch_limit_ff  <= PITCH_LIMIT_RESET;
         calibrated_ff   <= 1'b0;
         seen_ff         <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         confirm_time_ff <= confirm_time_in;
         yaw_limit_ff    <= yaw_limit_in;
         pitch_limit_ff  <= pitch_limit_in;
         calibrated_ff   <= calibrated_in;
         seen_ff         <= seen_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      s_func_ff       <= s_func_in;
      s_time_ff       <= s_time_in;
      s_ok_ff         <= s_ok_in;
      s_yaw_ff        <= s_yaw_in;
      s_pitch_ff      <= s_pitch_in;
      s_roll_ff       <= s_roll_in;
      s_fit_ff        <= s_fit_in;
      last_time_ff    <= last_time_in;
      window_start_ff <= window_start_in;
      yaw_low_ff      <= yaw_low_in;
      yaw_high_ff     <= yaw_high_in;
      pitch_low_ff    <= pitch_low_in;
      pitch_high_ff   <= pitch_high_in;
      yaw_total_ff    <= yaw_total_in;
      pitch_total_ff  <= pitch_total_in;
      yaw_offset_ff   <= yaw_offset_in;
      pitch_offset_ff <= pitch_offset_in;
      yaw_neg_ff      <= yaw_neg_in;
      pitch_neg_ff    <= pitch_neg_in;
      rsp_yaw_ff      <= rsp_yaw_in;
      rsp_pitch_ff    <= rsp_pitch_in;
      rsp_roll_ff     <= rsp_roll_in;
      rsp_fit_ff      <= rsp_fit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_out       = rsp_yaw_ff;
   assign rsp_pitch_out     = rsp_pitch_ff;
   assign rsp_roll_out      = rsp_roll_ff;
   assign rsp_fit_error_out = rsp_fit_ff;

endmodule

`default_nettype wire

FILE: rtl/core/npc_ctrl.sv
`default_nettype none

module npc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  npc_pkg::npc_status_type  status,
   output npc_pkg::npc_cmd_type     cmd
);
   import npc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_EVAL    = 6'b000010,
      ST_CHECK   = 6'b000100,
      ST_CONFIRM = 6'b001000,
      ST_DIVIDE  = 6'b010000,
      ST_EMIT    = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.restart) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.skip) begin
               state_in = ST_IDLE;
            end else if (status.calibrated) begin
               cmd.mark_time = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.mark_time = 1'b1;
               cmd.track     = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.spread_over) begin
               cmd.restart_window = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               cmd.accumulate = 1'b1;
               state_in       = ST_CONFIRM;
            end
         end
         ST_CONFIRM: begin
            if (status.confirm_wait) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               cmd.set_offsets = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/neutral_pose_calibrator_unit.sv
`default_nettype none

// Neutral pose calibrator. Takes timestamped yaw/pitch/roll/fit-error beats,
// drops invalid or non-increasing samples, and learns neutral yaw and pitch as
// the rounded means over a window whose spreads stay within the configured
// limits for confirm_time microseconds (or until the sample count reaches its
// bound). From the confirming sample onwards each sample comes out with the
// offsets subtracted; before that no result is produced. A restart beat
// (func = 1) clears the calibration, and any zero register disables the block.
// One item is in flight at a time: a restart or dropped sample visits idle and
// evaluate; a sample after calibration adds emit; an uncalibrated one adds
// check and confirm (only check when it reopens the window); the confirming
// one adds check, confirm, divide, where the two 15-step shift-subtract
// dividers form the means in parallel, and emit. A sample with a result waits
// in emit only while the previous result still waits in the output register
// under stall. The result sits in an output register, so a stalled result
// does not hold up the next sample's work until it too must be emitted.

module neutral_pose_calibrator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [npc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [npc_pkg::TIME_W-1:0]             req_sample_time,
   input  logic                                   req_angles_ok,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_yaw_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_pitch_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_roll_in,
   input  logic [npc_pkg::FIT_W-1:0]              req_fit_error_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_yaw_out,
   output logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_pitch_out,
   output logic signed [npc_pkg::ANGLE_W-1:0]     rsp_roll_out,
   output logic [npc_pkg::FIT_W-1:0]              rsp_fit_error_out
);
   import npc_pkg::*;

   npc_cmd_type    cmd;
   npc_status_type status;

   // sequencing
   npc_ctrl ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // state, arithmetic and result register
   npc_datapath datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_sample_time   (req_sample_time),
      .req_angles_ok     (req_angles_ok),
      .req_yaw_in        (req_yaw_in),
      .req_pitch_in      (req_pitch_in),
      .req_roll_in       (req_roll_in),
      .req_fit_error_in  (req_fit_error_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_yaw_out       (rsp_yaw_out),
      .rsp_pitch_out     (rsp_pitch_out),
      .rsp_roll_out      (rsp_roll_out),
      .rsp_fit_error_out (rsp_fit_error_out)
   );

endmodule

`default_nettype wire

FILE: tb/neutral_pose_calibrator_unit_checker.sv
`timescale 1ns / 1ps

module neutral_pose_calibrator_unit_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [npc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [npc_pkg::TIME_W-1:0]             req_sample_time,
   input  logic                                   req_angles_ok,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_yaw_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_pitch_in,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     req_roll_in,
   input  logic [npc_pkg::FIT_W-1:0]              req_fit_error_in,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_yaw_out,
   input  logic signed [npc_pkg::OUT_ANGLE_W-1:0] rsp_pitch_out,
   input  logic signed [npc_pkg::ANGLE_W-1:0]     rsp_roll_out,
   input  logic [npc_pkg::FIT_W-1:0]              rsp_fit_error_out,
   output int                                     mismatch_count,
   output int                                     pending_count,
   output int                                     checked_count
);
   import npc_pkg::*;

   typedef struct packed {
      logic signed [OUT_ANGLE_W-1:0] yaw;
      logic signed [OUT_ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0]     roll;
      logic [FIT_W-1:0]              fit;
   } corrected_pose_type;

   // shadow registers
   logic [CONFIRM_W-1:0] confirm_us;
   logic [LIMIT_W-1:0]   yaw_limit;
   logic [LIMIT_W-1:0]   pitch_limit;

   // learning state
   bit                   calibrated;
   bit                   stamp_seen;
   logic [TIME_W-1:0]    last_stamp;
   logic [TIME_W-1:0]    window_stamp;
   int                   yaw_min, yaw_max, pitch_min, pitch_max;
   longint               yaw_sum, pitch_sum;
   int                   window_count;
   int                   yaw_neutral, pitch_neutral;

   corrected_pose_type   expected_poses[$];
   int                   faults = 0;
   int                   checked = 0;

   function automatic void clear_calibration();
      calibrated    = 1'b0;
      stamp_seen    = 1'b0;
      last_stamp    = '0;
      window_stamp  = '0;
      yaw_min       = 0;
      yaw_max       = 0;
      pitch_min     = 0;
      pitch_max     = 0;
      yaw_sum       = 0;
      pitch_sum     = 0;
      window_count  = 0;
      yaw_neutral   = 0;
      pitch_neutral = 0;
   endfunction

   function automatic void open_window(logic [TIME_W-1:0] stamp, int yaw, int pitch);
      window_stamp = stamp;
      yaw_min      = yaw;
      yaw_max      = yaw;
      pitch_min    = pitch;
      pitch_max    = pitch;
   endfunction

   // mean rounded to nearest, halves away from zero
   function automatic int neutral_mean(longint sum, int count);
      longint mag;
      longint quo;
      mag = (sum < 0) ? -sum : sum;
      quo = (mag + count / 2) / count;
      return (sum < 0) ? -int'(quo) : int'(quo);
   endfunction

   // advance the learning state by one beat; returns 1 when a pose comes out
   function automatic bit calibrate_step(input logic func, input logic [TIME_W-1:0] stamp,
                                         input logic ok, input int yaw, input int pitch,
                                         input int roll, input logic [FIT_W-1:0] fit,
                                         output corrected_pose_type pose);
      logic [TIME_W-1:0] elapsed;
      pose = '0;
      if (func) begin
         clear_calibration();
         return 1'b0;
      end
      if (confirm_us == 0 || yaw_limit == 0 || pitch_limit == 0) return 1'b0;
      if (!ok) return 1'b0;
      if (stamp_seen && stamp <= last_stamp) return 1'b0;
      stamp_seen = 1'b1;
      last_stamp = stamp;

      if (!calibrated) begin
         if (window_count == 0) begin
            open_window(stamp, yaw, pitch);
         end else begin
            if (yaw < yaw_min) yaw_min = yaw;
            if (yaw > yaw_max) yaw_max = yaw;
            if (pitch < pitch_min) pitch_min = pitch;
            if (pitch > pitch_max) pitch_max = pitch;
            // spread too wide: this sample starts a fresh window
            if (yaw_max - yaw_min > int'(yaw_limit) ||
                pitch_max - pitch_min > int'(pitch_limit)) begin
               open_window(stamp, yaw, pitch);
               yaw_sum      = yaw;
               pitch_sum    = pitch;
               window_count = 1;
               return 1'b0;
            end
         end
         yaw_sum      += yaw;
         pitch_sum    += pitch;
         window_count += 1;
         elapsed = stamp - window_stamp;
         if (elapsed < confirm_us && window_count < MAX_SAMPLES) return 1'b0;
         yaw_neutral   = neutral_mean(yaw_sum, window_count);
         pitch_neutral = neutral_mean(pitch_sum, window_count);
         calibrated    = 1'b1;
      end

      pose.yaw   = OUT_ANGLE_W'(yaw - yaw_neutral);
      pose.pitch = OUT_ANGLE_W'(pitch - pitch_neutral);
      pose.roll  = ANGLE_W'(roll);
      pose.fit   = fit;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      corrected_pose_type predicted;
      corrected_pose_type observed;
      if (reset) begin
         confirm_us  = CONFIRM_TIME_RESET;
         yaw_limit   = YAW_LIMIT_RESET;
         pitch_limit = PITCH_LIMIT_RESET;
         clear_calibration();
         expected_poses.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CONFIRM_TIME: confirm_us  = csr_write_data[CONFIRM_W-1:0];
               CSR_YAW_LIMIT:    yaw_limit   = csr_write_data[LIMIT_W-1:0];
               CSR_PITCH_LIMIT:  pitch_limit = csr_write_data[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // accepted sample beat
         if (req_valid && !req_stall) begin
            if (calibrate_step(req_func, req_sample_time, req_angles_ok, int'(req_yaw_in),
                               int'(req_pitch_in), int'(req_roll_in), req_fit_error_in,
                               predicted))
               expected_poses.push_back(predicted);
         end

         // accepted result beat
         if (rsp_valid && !rsp_stall) begin
            observed.yaw   = rsp_yaw_out;
            observed.pitch = rsp_pitch_out;
            observed.roll  = rsp_roll_out;
            observed.fit   = rsp_fit_error_out;
            if (expected_poses.size() == 0) begin
               if (faults < 10)
                  $display("%t: unexpected pose beat yaw %0d pitch %0d roll %0d fit %0d",
                           $time, observed.yaw, observed.pitch, observed.roll, observed.fit);
               faults++;
            end else begin
               predicted = expected_poses.pop_front();
               checked++;
               if (observed.yaw !== predicted.yaw || observed.pitch !== predicted.pitch ||
                   observed.roll !== predicted.roll || observed.fit !== predicted.fit) begin
                  if (faults < 10) begin
                     $display("%t: pose check failed", $time);
                     $display("   expected yaw %0d pitch %0d roll %0d fit %0d",
                              predicted.yaw, predicted.pitch, predicted.roll, predicted.fit);
                     $display("   actual   yaw %0d pitch %0d roll %0d fit %0d",
                              observed.yaw, observed.pitch, observed.roll, observed.fit);
                  end
                  faults++;
               end
            end
         end
      end
      mismatch_count <= faults;
      checked_count  <= checked;
      pending_count  <= expected_poses.size();
   end

endmodule

FILE: tb/neutral_pose_calibrator_unit_test.sv
`timescale 1ns / 1ps

module neutral_pose_calibrator_unit_test;
   import npc_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write_enable;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_write_data;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_func;
   logic [TIME_W-1:0]             req_sample_time;
   logic                          req_angles_ok;
   logic signed [ANGLE_W-1:0]     req_yaw_in;
   logic signed [ANGLE_W-1:0]     req_pitch_in;
   logic signed [ANGLE_W-1:0]     req_roll_in;
   logic [FIT_W-1:0]              req_fit_error_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [OUT_ANGLE_W-1:0] rsp_yaw_out;
   logic signed [OUT_ANGLE_W-1:0] rsp_pitch_out;
   logic signed [ANGLE_W-1:0]     rsp_roll_out;
   logic [FIT_W-1:0]              rsp_fit_error_out;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int beats_sent = 0;
   logic [TIME_W-1:0]    stamp_now;
   logic [CONFIRM_W-1:0] cfg_confirm;
   logic [LIMIT_W-1:0]   cfg_yaw_limit;
   logic [LIMIT_W-1:0]   cfg_pitch_limit;

   neutral_pose_calibrator_unit i_dut (.*);

   neutral_pose_calibrator_unit_checker i_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic int any_angle();
      return int'($urandom_range(23040)) - 11520;
   endfunction

   function automatic int clamp_angle(int v);
      if (v > 11520) return 11520;
      if (v < -11520) return -11520;
      return v;
   endfunction

   // one beat on the sample channel, entered and left at a falling edge
   task automatic send_beat(input logic func, input logic [TIME_W-1:0] stamp, input logic ok,
                            input int yaw, input int pitch, input int roll, input int fit);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_sample_time  <= stamp;
      req_angles_ok    <= ok;
      req_yaw_in       <= ANGLE_W'(yaw);
      req_pitch_in     <= ANGLE_W'(pitch);
      req_roll_in      <= ANGLE_W'(roll);
      req_fit_error_in <= FIT_W'(fit);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic pose(input logic [TIME_W-1:0] stamp, input int yaw, input int pitch);
      send_beat(1'b0, stamp, 1'b1, yaw, pitch, any_angle(), $urandom_range(65535));
   endtask

   task automatic restart_beat();
      send_beat(1'b1, {16'($urandom), $urandom}, $urandom_range(1), any_angle(), any_angle(),
                any_angle(), $urandom_range(65535));
   endtask

   // hold the sender until every expected pose is back, then let the block settle
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_count != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_CONFIRM_TIME: cfg_confirm     = value[CONFIRM_W-1:0];
         CSR_YAW_LIMIT:    cfg_yaw_limit   = value[LIMIT_W-1:0];
         CSR_PITCH_LIMIT:  cfg_pitch_limit = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // head-still sessions with random content, plus dropped, stale and wild beats
   task automatic run_sessions(input int beats);
      int done, span, pick, parts, jit_yaw, jit_pitch, centre_yaw, centre_pitch, back;
      longint unsigned step;
      logic [TIME_W-1:0] base;
      done = 0;
      while (done < beats) begin
         base = {16'($urandom), $urandom};
         if (base[47:43] == 5'h1f) base[43] = 1'b0;
         stamp_now = base;
         restart_beat();
         parts        = $urandom_range(1, 12);
         step         = longint'(cfg_confirm) / parts;
         jit_yaw      = cfg_yaw_limit / 4;
         jit_pitch    = cfg_pitch_limit / 4;
         centre_yaw   = any_angle();
         centre_pitch = any_angle();
         span         = $urandom_range(20, 80);
         for (int k = 0; k < span; k++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
               restart_beat();
            end else if (pick < 8) begin
               stamp_now += step + $urandom_range(1, 3);
               send_beat(1'b0, stamp_now, 1'b0, any_angle(), any_angle(), any_angle(),
                         $urandom_range(65535));
            end else if (pick < 12) begin
               back = $urandom_range(3);
               pose(stamp_now - back, centre_yaw, centre_pitch);
            end else if (pick < 17) begin
               stamp_now += step + $urandom_range(1, 3);
               if ($urandom_range(1)) begin
                  centre_yaw   = any_angle();
                  centre_pitch = any_angle();
               end
               pose(stamp_now, any_angle(), any_angle());
            end else begin
               stamp_now += step + $urandom_range(1, 3);
               pose(stamp_now,
                    clamp_angle(centre_yaw + int'($urandom_range(2 * jit_yaw)) - jit_yaw),
                    clamp_angle(centre_pitch + int'($urandom_range(2 * jit_pitch)) - jit_pitch));
            end
         end
         done += span + 1;
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [CONFIRM_W-1:0] confirm,
                            input int yaw_limit, input int pitch_limit);
      drain();
      write_reg(CSR_CONFIRM_TIME, confirm);
      write_reg(CSR_YAW_LIMIT, yaw_limit);
      write_reg(CSR_PITCH_LIMIT, pitch_limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      run_sessions(350);
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_CONFIRM_TIME;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_func         = 1'b0;
      req_sample_time  = '0;
      req_angles_ok    = 1'b0;
      req_yaw_in       = '0;
      req_pitch_in     = '0;
      req_roll_in      = '0;
      req_fit_error_in = '0;
      cfg_confirm      = CONFIRM_TIME_RESET;
      cfg_yaw_limit    = YAW_LIMIT_RESET;
      cfg_pitch_limit  = PITCH_LIMIT_RESET;
      stamp_now        = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // restart and unusable angles before anything is learnt
      send_beat(1'b1, {TIME_W{1'b1}}, 1'b1, 11520, -11520, 0, 0);
      send_beat(1'b0, 500, 1'b0, 0, 0, 0, 0);
      // window start, repeated and older stamps dropped
      pose(1000, -11520, 11520);
      pose(1000, -11520, 11520);
      pose(999, 0, 0);
      // yaw spread one past the limit reopens the window, twice
      pose(1010, -10879, 11520);
      pose(1020, -11520, 11520);
      // window held for the confirm time
      pose(1001020, -11520, 11520);
      // largest corrections after calibration
      send_beat(1'b0, 1001021, 1'b1, 11520, -11520, 11520, 65535);
      send_beat(1'b0, 1001022, 1'b0, 0, 0, -11520, 0);
      pose(1001023, 0, 0);
      send_beat(1'b1, 0, 1'b0, -11520, 11520, -11520, 0);
      // negative and positive halves round away from zero
      pose(5, -1, 1);
      pose(1000005, -2, 2);
      pose(1000006, 0, 0);
      restart_beat();
      // spread exceeded on the sample that would confirm
      pose(10, 0, 0);
      pose(2000010, 0, 641);
      pose(3000010, 0, 641);

      // each register at zero turns the block off
      drain();
      write_reg(CSR_CONFIRM_TIME, 0);
      pose(3000011, 100, 100);
      drain();
      write_reg(CSR_CONFIRM_TIME, 1);
      pose(3000012, 5, 5);
      drain();
      write_reg(CSR_YAW_LIMIT, 0);
      pose(3000013, 6, 6);
      drain();
      write_reg(CSR_YAW_LIMIT, 1);
      write_reg(CSR_PITCH_LIMIT, 0);
      restart_beat();
      pose(1, 0, 0);
      drain();
      write_reg(CSR_PITCH_LIMIT, 1);
      pose(1, 0, 0);
      pose(2, 1, 1);
      pose(3, 1, 0);

      // random sessions under each pacing
      run_phase(0, 0, 1000000, 640, 640);
      run_phase(76, 0, 1, 1, 1);
      run_phase(0, 76, 5000, 23040, 23040);
      run_phase(28, 28, 32'hFFFF_FFFF, $urandom_range(1, 23040), $urandom_range(1, 23040));

      drain();
      $display("%0d sample beats sent, %0d corrected poses checked", beats_sent,
               checked_count);
      $display("covered restarts, dropped beats, window reopening, disabled block");
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/npc_pkg.sv
rtl/core/npc_divider.sv
rtl/core/npc_datapath.sv
rtl/core/npc_ctrl.sv
rtl/core/neutral_pose_calibrator_unit.sv
tb/neutral_pose_calibrator_unit_checker.sv
tb/neutral_pose_calibrator_unit_test.sv
